// ===== design/mbe_pkg.sv =====
// Shared types, widths and helpers for the Mandelbrot escape-time block.
// No dependencies; mbe_datapath, mbe_ctrl, the top level and the testbench import this package.
package mbe_pkg;

  localparam int DATA_W    = 32;
  localparam int ZOOM_W    = 31;
  localparam int COUNT_W   = 16;
  localparam int PIX_W     = 10;
  localparam int INDEX_W   = 20;
  localparam int CFG_IDX_W = 3;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int MAG_W     = DATA_W + PIX_W;

  localparam int DEF_IMAGE_WIDTH   = 1024;
  localparam int DEF_IMAGE_HEIGHT  = 1024;
  localparam int DEF_FRACTION_BITS = 28;

  localparam logic [COUNT_W-1:0] MAX_ITER_RST = 16'd256;

  localparam logic signed [63:0] WIDE_MAX = 64'(32'sh7fffffff);
  localparam logic signed [63:0] WIDE_MIN = 64'(32'sh80000000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REAL_MIN = 3'd0,
    REG_REAL_MAX = 3'd1,
    REG_IMAG_MIN = 3'd2,
    REG_IMAG_MAX = 3'd3,
    REG_ZOOM     = 3'd4,
    REG_MAX_ITER = 3'd5
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_LOAD,
    S_DIV_RUN,
    S_MAP,
    S_ZOOM,
    S_SQUARE,
    S_UPDATE
  } mbe_state_t;

  typedef struct packed {
    logic load;
    logic div_load;
    logic axis;
    logic set_mapped;
    logic set_c;
    logic square;
    logic update;
    logic finish;
  } mbe_cmd_t;

  typedef struct packed {
    logic div_done;
    logic at_limit;
    logic escaped;
  } mbe_stat_t;

  function automatic logic signed [DATA_W-1:0] saturate(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > WIDE_MAX) begin
      r = WIDE_MAX[DATA_W-1:0];
    end else if (v < WIDE_MIN) begin
      r = WIDE_MIN[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/mbe_div.sv =====
// Constant divider: reciprocal multiplication with one correction step, in two chunks.
// Depends on nothing; used by the datapath for the coordinate mapping.
module mbe_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 11,
  parameter int DEN_A = 1024,
  parameter int DEN_B = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             sel,
  input  logic [NUM_W-1:0] numer,
  output logic [NUM_W-1:0] quot,
  output logic             done
);
  localparam int LO_W   = NUM_W / 2;
  localparam int HI_W   = NUM_W - LO_W;
  localparam int X_W    = (DEN_W + LO_W > HI_W) ? DEN_W + LO_W : HI_W;
  localparam int PROD_W = 2 * X_W;
  localparam int QD_W   = X_W + DEN_W;

  localparam logic [X_W-1:0] REC_A = X_W'((longint'(1) << X_W) / DEN_A);
  localparam logic [X_W-1:0] REC_B = X_W'((longint'(1) << X_W) / DEN_B);

  logic [X_W-1:0]    x, q_est, qd, rec_q;
  logic [DEN_W-1:0]  den_q;
  logic [LO_W-1:0]   lo_part;
  logic [HI_W-1:0]   q_hi;
  logic              second, mul_go, prod_go, fix_go;
  logic [PROD_W-1:0] rec_prod;
  logic [QD_W-1:0]   qd_prod;
  logic [X_W-1:0]    r_raw, r_fix, q_fix;
  logic              fits;

  // The partial dividend stays below 2^X_W, so the estimate is low by at most one.
  always_comb begin
    rec_prod = PROD_W'(x) * PROD_W'(rec_q);
    qd_prod  = QD_W'(q_est) * QD_W'(den_q);
    r_raw    = x - qd;
    fits     = r_raw >= X_W'(den_q);
    q_fix    = q_est + X_W'(fits);
    r_fix    = fits ? r_raw - X_W'(den_q) : r_raw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go  <= 1'b0;
      prod_go <= 1'b0;
      fix_go  <= 1'b0;
      done    <= 1'b0;
    end else begin
      mul_go  <= start || (fix_go && !second);
      prod_go <= mul_go;
      fix_go  <= prod_go;
      done    <= fix_go && second;
    end
  end

  // The upper chunk is divided first; its remainder is carried into the lower one.
  always_ff @(posedge clk) begin
    if (start) begin
      x       <= X_W'(numer[NUM_W-1:LO_W]);
      lo_part <= numer[LO_W-1:0];
      second  <= 1'b0;
      den_q   <= sel ? DEN_W'(DEN_B) : DEN_W'(DEN_A);
      rec_q   <= sel ? REC_B : REC_A;
    end else if (fix_go) begin
      if (!second) begin
        q_hi   <= q_fix[HI_W-1:0];
        x      <= X_W'({r_fix[DEN_W-1:0], lo_part});
        second <= 1'b1;
      end else begin
        quot <= {q_hi, q_fix[LO_W-1:0]};
      end
    end
    if (mul_go) begin
      q_est <= rec_prod[PROD_W-1:X_W];
    end
    if (prod_go) begin
      qd <= qd_prod[X_W-1:0];
    end
  end

endmodule

// ===== design/mbe_datapath.sv =====
// Datapath: configuration registers, coordinate mapping and the z = z^2 + c step.
// Depends on mbe_pkg and mbe_div; driven by mbe_ctrl through mbe_cmd_t.
module mbe_datapath #(
  parameter int IMAGE_WIDTH   = mbe_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT  = mbe_pkg::DEF_IMAGE_HEIGHT,
  parameter int FRACTION_BITS = mbe_pkg::DEF_FRACTION_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  mbe_pkg::mbe_cmd_t              cmd,
  output mbe_pkg::mbe_stat_t             stat,
  input  logic [mbe_pkg::PIX_W-1:0]      pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]      pixel_y,
  input  logic                           cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbe_pkg::DATA_W-1:0]     cfg_data,
  output logic                           done,
  output logic [mbe_pkg::COUNT_W-1:0]    iteration_count,
  output logic [mbe_pkg::INDEX_W-1:0]    pixel_index
);
  import mbe_pkg::*;

  localparam int SPAN_MAX = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
  localparam int SPAN_W   = $clog2(SPAN_MAX + 1);

  localparam logic signed [DATA_W-1:0] FX_ONE      = DATA_W'(1) << FRACTION_BITS;
  localparam logic signed [DATA_W-1:0] RE_MIN_RST  = -(FX_ONE + FX_ONE);
  localparam logic signed [DATA_W-1:0] IM_MIN_RST  = -FX_ONE;
  localparam logic signed [DATA_W+1:0] ESC_LIMIT   = (DATA_W+2)'(4) <<< FRACTION_BITS;

  logic signed [DATA_W-1:0] real_min, real_max, imag_min, imag_max;
  logic        [ZOOM_W-1:0] zoom;
  logic       [COUNT_W-1:0] iter_limit;

  logic [PIX_W-1:0]   px_q, py_q;
  logic [INDEX_W-1:0] index_q;
  logic               num_neg;
  logic signed [DATA_W-1:0] mapped, c_re, c_im, re, im, rr, ii, ri;
  logic [COUNT_W-1:0] count;

  logic signed [DATA_W-1:0]     lo, hi;
  logic [PIX_W-1:0]             p;
  logic signed [DIFF_W-1:0]     diff;
  logic signed [DIFF_W+PIX_W:0] num;
  logic [MAG_W-1:0]             num_mag;
  logic [MAG_W-1:0]             quot;
  logic                         div_done;
  logic signed [MAG_W:0]        t;
  logic signed [MAG_W+1:0]      map_sum;
  logic signed [63:0]           zprod, prod_rr, prod_ii, prod_ri;
  logic signed [DATA_W-1:0]     c_next;
  logic signed [DATA_W+1:0]     mag2, re_sum, im_sum;
  logic [INDEX_W-1:0]           index_next;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      real_min   <= RE_MIN_RST;
      real_max   <= FX_ONE;
      imag_min   <= IM_MIN_RST;
      imag_max   <= FX_ONE;
      zoom       <= ZOOM_W'(FX_ONE);
      iter_limit <= MAX_ITER_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_REAL_MIN: real_min   <= cfg_data;
        REG_REAL_MAX: real_max   <= cfg_data;
        REG_IMAG_MIN: imag_min   <= cfg_data;
        REG_IMAG_MAX: imag_max   <= cfg_data;
        REG_ZOOM:     zoom       <= cfg_data[ZOOM_W-1:0];
        REG_MAX_ITER: iter_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Axis mapping: t = trunc((hi - lo) * p / span), done as sign and magnitude.
  always_comb begin
    lo      = cmd.axis ? imag_min : real_min;
    hi      = cmd.axis ? imag_max : real_max;
    p       = cmd.axis ? py_q : px_q;
    diff    = DIFF_W'(hi) - DIFF_W'(lo);
    num     = diff * $signed({1'b0, p});
    num_mag = MAG_W'(num[DIFF_W+PIX_W] ? -num : num);
    t       = num_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    map_sum = (MAG_W+2)'(lo) + (MAG_W+2)'(t);
    zprod   = mapped * $signed({1'b0, zoom});
    c_next  = saturate(zprod >>> FRACTION_BITS);
  end

  mbe_div #(
    .NUM_W (MAG_W),
    .DEN_W (SPAN_W),
    .DEN_A (IMAGE_WIDTH),
    .DEN_B (IMAGE_HEIGHT)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_load),
    .sel   (cmd.axis),
    .numer (num_mag),
    .quot  (quot),
    .done  (div_done)
  );

  // Iteration arithmetic: squares are registered, then tested and summed.
  always_comb begin
    prod_rr = re * re;
    prod_ii = im * im;
    prod_ri = re * im;
    mag2    = (DATA_W+2)'(rr) + (DATA_W+2)'(ii);
    re_sum  = (DATA_W+2)'(rr) - (DATA_W+2)'(ii) + (DATA_W+2)'(c_re);
    im_sum  = ((DATA_W+2)'(ri) <<< 1) + (DATA_W+2)'(c_im);
    index_next = INDEX_W'(pixel_x) + INDEX_W'(pixel_y) * INDEX_W'(IMAGE_WIDTH);
  end

  assign stat.div_done = div_done;
  assign stat.at_limit = count >= iter_limit;
  assign stat.escaped  = mag2 > ESC_LIMIT;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_q    <= pixel_x;
      py_q    <= pixel_y;
      index_q <= index_next;
    end
    if (cmd.div_load) begin
      num_neg <= num[DIFF_W+PIX_W];
    end
    if (cmd.set_mapped) begin
      mapped <= saturate(64'(map_sum));
    end
    if (cmd.set_c) begin
      if (cmd.axis) begin
        c_im <= c_next;
      end else begin
        c_re <= c_next;
      end
      re    <= '0;
      im    <= '0;
      count <= '0;
    end
    if (cmd.square) begin
      rr <= saturate(prod_rr >>> FRACTION_BITS);
      ii <= saturate(prod_ii >>> FRACTION_BITS);
      ri <= saturate(prod_ri >>> FRACTION_BITS);
    end
    if (cmd.update) begin
      re    <= saturate(64'(re_sum));
      im    <= saturate(64'(im_sum));
      count <= count + COUNT_W'(1);
    end
    if (cmd.finish) begin
      iteration_count <= count;
      pixel_index     <= index_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

// ===== design/mbe_ctrl.sv =====
// Controller state machine that sequences mapping and iteration for one pixel.
// Depends on mbe_pkg; commands the datapath and reads its status.
module mbe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  mbe_pkg::mbe_stat_t stat,
  output mbe_pkg::mbe_cmd_t  cmd
);
  import mbe_pkg::*;

  mbe_state_t state, state_next;
  logic       axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      S_IDLE: begin
        axis_next = 1'b0;
        if (start) begin
          state_next = S_DIV_LOAD;
        end
      end
      S_DIV_LOAD: state_next = S_DIV_RUN;
      S_DIV_RUN: begin
        if (stat.div_done) begin
          state_next = S_MAP;
        end
      end
      S_MAP: state_next = S_ZOOM;
      S_ZOOM: begin
        axis_next  = 1'b1;
        state_next = axis ? S_SQUARE : S_DIV_LOAD;
      end
      S_SQUARE: state_next = stat.at_limit ? S_IDLE : S_UPDATE;
      S_UPDATE: state_next = stat.escaped ? S_IDLE : S_SQUARE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.axis = axis;
    busy     = state != S_IDLE;
    case (state)
      S_IDLE:     cmd.load       = start;
      S_DIV_LOAD: cmd.div_load   = 1'b1;
      S_MAP:      cmd.set_mapped = 1'b1;
      S_ZOOM:     cmd.set_c      = 1'b1;
      S_SQUARE: begin
        cmd.finish = stat.at_limit;
        cmd.square = !stat.at_limit;
      end
      S_UPDATE: begin
        cmd.finish = stat.escaped;
        cmd.update = !stat.escaped;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time block.
// Depends on mbe_pkg, mbe_ctrl, mbe_datapath and mbe_div.
//
// Usage:
//   A pixel is transferred in at a rising edge with start high and busy low;
//   pixel_x and pixel_y are sampled at that edge. The configuration port
//   (cfg_write, cfg_index, cfg_data) writes one register per edge and should
//   only be used while busy is low.
//   Each pixel gives one result: done is high for exactly one cycle while
//   iteration_count and pixel_index hold the result. The receiver cannot stall;
//   it must take the transfer in that cycle. busy is already low in the done
//   cycle, so the next pixel may be started there.
// Sequence:
//   Each axis maps in order: setup, the constant divider, then the edge
//   offset and the zoom product. Each step then forms the products, then
//   does the escape test and update. No new pixel is taken while busy is high.
// Reset:
//   rst is synchronous; it returns the controller to idle, drops done, and
//   loads the configuration registers with their default window, zoom and limit.
module mandelbrot_escape_time #(
  parameter int IMAGE_WIDTH   = mbe_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT  = mbe_pkg::DEF_IMAGE_HEIGHT,
  parameter int FRACTION_BITS = mbe_pkg::DEF_FRACTION_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mbe_pkg::PIX_W-1:0]     pixel_x,
  input  logic [mbe_pkg::PIX_W-1:0]     pixel_y,
  input  logic                          cfg_write,
  input  logic [mbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mbe_pkg::DATA_W-1:0]    cfg_data,
  output logic                          done,
  output logic [mbe_pkg::COUNT_W-1:0]   iteration_count,
  output logic [mbe_pkg::INDEX_W-1:0]   pixel_index
);
  import mbe_pkg::*;

  mbe_cmd_t  cmd;
  mbe_stat_t stat;

  mbe_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mbe_datapath #(
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .IMAGE_HEIGHT  (IMAGE_HEIGHT),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .iteration_count (iteration_count),
    .pixel_index     (pixel_index)
  );

endmodule

// ===== design/mbe_checker.sv =====
// Port-level checks for the Mandelbrot escape-time block, bound to the top level.
// Depends only on the top level's ports.
module mbe_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // A result is only delivered once the block has gone idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result delivered while busy");

  // Every result ends a busy period.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a pixel in progress");

  // Finishing a pixel always delivers its result.
  a_fall_gives_done: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without a result");

  // An accepted pixel makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted pixel did not start work");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

// ===== tb/mandelbrot_escape_time_tb.sv =====
// Self-checking testbench for the Mandelbrot escape-time block.
// Depends on mbe_pkg and mandelbrot_escape_time; it predicts every pixel result
// with its own fixed-point escape-time model and checks each done transfer.
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
  import mbe_pkg::*;

  localparam int     FRAC         = DEF_FRACTION_BITS;
  localparam int     IMG_W        = DEF_IMAGE_WIDTH;
  localparam int     IMG_H        = DEF_IMAGE_HEIGHT;
  localparam longint Q_ONE        = longint'(1) << FRAC;
  localparam longint ESCAPE_LIMIT = longint'(4) << FRAC;
  localparam longint CYCLE_LIMIT  = 4000000;
  localparam int     DRAIN_CYCLES = 200;

  // Indexes the block decodes to nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [INDEX_W-1:0] index;
  } pixel_result_t;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_x   = '0;
  logic [PIX_W-1:0]     pixel_y   = '0;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data  = '0;
  logic                 done;
  logic [COUNT_W-1:0]   iteration_count;
  logic [INDEX_W-1:0]   pixel_index;

  // Shadow copy of the configuration registers, at their reset values.
  logic signed [DATA_W-1:0] re_lo_q      = -32'sh2000_0000;
  logic signed [DATA_W-1:0] re_hi_q      = 32'sh1000_0000;
  logic signed [DATA_W-1:0] im_lo_q      = -32'sh1000_0000;
  logic signed [DATA_W-1:0] im_hi_q      = 32'sh1000_0000;
  logic [ZOOM_W-1:0]        zoom_q       = 31'h1000_0000;
  logic [COUNT_W-1:0]       iter_limit_q = MAX_ITER_RST;

  pixel_t        pixel_q[$];
  pixel_result_t escape_exp_q[$];
  int            idle_pct   = 0;
  int            errors     = 0;
  longint        cycle_cnt  = 0;

  mandelbrot_escape_time u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .iteration_count (iteration_count),
    .pixel_index     (pixel_index)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint sat_q(input longint v);
    if (v > longint'(32'sh7fff_ffff)) begin
      return longint'(32'sh7fff_ffff);
    end
    if (v < longint'(32'sh8000_0000)) begin
      return longint'(32'sh8000_0000);
    end
    return v;
  endfunction

  // Exact product, floor shift by the fraction width, then saturation.
  function automatic longint mul_q(input longint a, input longint b);
    return sat_q((a * b) >>> FRAC);
  endfunction

  function automatic longint map_axis(input longint lo, input longint hi,
                                      input longint p, input longint span);
    longint t;
    longint m;
    t = ((hi - lo) * p) / span;
    m = sat_q(lo + t);
    return sat_q((m * longint'(zoom_q)) >>> FRAC);
  endfunction

  function automatic pixel_result_t predict_escape(input logic [PIX_W-1:0] px,
                                                   input logic [PIX_W-1:0] py);
    longint        c_re;
    longint        c_im;
    longint        r;
    longint        i;
    longint        rr;
    longint        ii;
    longint        ri;
    int unsigned   n;
    pixel_result_t res;
    c_re = map_axis(longint'(re_lo_q), longint'(re_hi_q), longint'(px), IMG_W);
    c_im = map_axis(longint'(im_lo_q), longint'(im_hi_q), longint'(py), IMG_H);
    r = 0;
    i = 0;
    n = 0;
    while (n < iter_limit_q) begin
      rr = mul_q(r, r);
      ii = mul_q(i, i);
      if (rr + ii > ESCAPE_LIMIT) break;
      ri = mul_q(r, i);
      r = sat_q(rr - ii + c_re);
      i = sat_q(2 * ri + c_im);
      n++;
    end
    res.count = COUNT_W'(n);
    res.index = INDEX_W'(longint'(px) + longint'(py) * IMG_W);
    return res;
  endfunction

  // Driver: holds start until the block takes the pixel, then may idle.
  always @(posedge clk) begin
    pixel_t p;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        escape_exp_q.push_back(predict_escape(pixel_x, pixel_y));
      end
      if (!start || !busy) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          p = pixel_q.pop_front();
          start   <= 1'b1;
          pixel_x <= p.x;
          pixel_y <= p.y;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle is one result transfer.
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst && done) begin
      if (escape_exp_q.size() == 0) begin
        $display("%0t: result with nothing expected: count %0d index %0d",
                 $time, iteration_count, pixel_index);
        errors++;
      end else begin
        e = escape_exp_q.pop_front();
        if (iteration_count !== e.count) begin
          $display("%0t: iteration_count mismatch: expected %0d actual %0d",
                   $time, e.count, iteration_count);
          errors++;
        end
        if (pixel_index !== e.index) begin
          $display("%0t: pixel_index mismatch: expected %0d actual %0d",
                   $time, e.index, pixel_index);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** mandelbrot_escape_time: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_REAL_MIN: re_lo_q = data;
      REG_REAL_MAX: re_hi_q = data;
      REG_IMAG_MIN: im_lo_q = data;
      REG_IMAG_MAX: im_hi_q = data;
      REG_ZOOM:     zoom_q = data[ZOOM_W-1:0];
      REG_MAX_ITER: iter_limit_q = data[COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_config(input logic [DATA_W-1:0] re_lo, input logic [DATA_W-1:0] re_hi,
                              input logic [DATA_W-1:0] im_lo, input logic [DATA_W-1:0] im_hi,
                              input logic [DATA_W-1:0] zoom, input logic [DATA_W-1:0] iters);
    write_reg(REG_REAL_MIN, re_lo);
    write_reg(REG_REAL_MAX, re_hi);
    write_reg(REG_IMAG_MIN, im_lo);
    write_reg(REG_IMAG_MAX, im_hi);
    write_reg(REG_ZOOM, zoom);
    write_reg(REG_MAX_ITER, iters);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || start || escape_exp_q.size() != 0 || busy) begin
      @(negedge clk);
    end
  endtask

  task automatic queue_pixel(input int x, input int y);
    pixel_t p;
    p.x = PIX_W'(x);
    p.y = PIX_W'(y);
    pixel_q.push_back(p);
  endtask

  initial begin
    longint center_re;
    longint center_im;
    longint half_span;
    logic [DATA_W-1:0] zoom_val;
    logic [DATA_W-1:0] iter_val;
    int pick;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset window, the four corners and one interior point.
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(1023, 0);
    queue_pixel(0, 1023);
    queue_pixel(768, 512);
    wait_idle();

    // Unused indexes must leave the configuration alone.
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    queue_pixel(600, 400);
    wait_idle();

    // A zero iteration limit runs no step; zero zoom collapses c to the origin.
    apply_config(-32'sh2000_0000, 32'sh1000_0000, -32'sh1000_0000, 32'sh1000_0000, 32'h0, 32'h0);
    queue_pixel(100, 200);
    wait_idle();
    apply_config(-32'sh2000_0000, 32'sh1000_0000, -32'sh1000_0000, 32'sh1000_0000,
                 32'h7fff_ffff, 32'h1);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    wait_idle();

    // Full-range edges with an inverted imaginary axis and maximum zoom.
    apply_config(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                 32'hffff_ffff, 32'd300);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(512, 512);
    queue_pixel(1, 1022);
    wait_idle();

    // Inverted real axis at double zoom.
    apply_config(32'sh1000_0000, -32'sh2000_0000, -32'sh1000_0000, 32'sh1000_0000,
                 32'h2000_0000, 32'd100);
    queue_pixel($urandom_range(1023), $urandom_range(1023));
    queue_pixel($urandom_range(1023), $urandom_range(1023));
    queue_pixel($urandom_range(1023), $urandom_range(1023));
    wait_idle();

    // Largest limit: one point that never escapes and one that escapes early.
    apply_config(-32'sh2000_0000, 32'sh1000_0000, -32'sh1000_0000, 32'sh1000_0000,
                 32'h0, 32'hffff);
    queue_pixel($urandom_range(1023), $urandom_range(1023));
    wait_idle();
    write_reg(REG_ZOOM, 32'h1000_0000);
    queue_pixel(1023, 1023);
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      pick = $urandom_range(3);
      if (pick == 0) begin
        apply_config($urandom(), $urandom(), $urandom(), $urandom(), 32'h0, 32'h0);
      end else begin
        center_re = longint'($urandom_range(250)) * (Q_ONE / 100) - 2 * Q_ONE;
        center_im = longint'($urandom_range(200)) * (Q_ONE / 100) - Q_ONE;
        half_span = Q_ONE >>> $urandom_range(12);
        apply_config(DATA_W'(center_re - half_span), DATA_W'(center_re + half_span),
                     DATA_W'(center_im - half_span), DATA_W'(center_im + half_span),
                     32'h0, 32'h0);
      end

      pick = $urandom_range(7);
      if (pick == 0) begin
        zoom_val = $urandom();
      end else if (pick == 1) begin
        zoom_val = 32'h0;
      end else if (pick < 5) begin
        zoom_val = 32'h1000_0000;
      end else begin
        zoom_val = $urandom_range(32'h2000_0000, 32'h0400_0000);
      end
      write_reg(REG_ZOOM, zoom_val);

      if ($urandom_range(7) == 0) begin
        iter_val = $urandom_range(400, 65);
      end else begin
        iter_val = $urandom_range(64, 1);
      end
      write_reg(REG_MAX_ITER, iter_val);

      case (ph % 4)
        1:       idle_pct = 84;
        2:       idle_pct = 12;
        default: idle_pct = 0;
      endcase

      for (int k = 0; k < 55; k++) begin
        if ($urandom_range(15) == 0) begin
          queue_pixel($urandom_range(1) * 1023, $urandom_range(1) * 1023);
        end else begin
          queue_pixel($urandom_range(1023), $urandom_range(1023));
        end
      end
      wait_idle();
    end

    idle_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && escape_exp_q.size() == 0) begin
      $display("** mandelbrot_escape_time: PASSED **");
    end else begin
      $display("** mandelbrot_escape_time: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/mbe_pkg.sv
design/mbe_div.sv
design/mbe_datapath.sv
design/mbe_ctrl.sv
design/mandelbrot_escape_time.sv
design/mbe_checker.sv
tb/mandelbrot_escape_time_tb.sv
